// ----- hdl/tvpc_pkg.sv -----
`default_nettype none
package tvpc_pkg;
    localparam int CoefFrac = 12;
    localparam int NumRegs  = 8;

    typedef enum logic [2:0] {
        REG_ROW_X   = 3'd0,
        REG_ROW_Y   = 3'd1,
        REG_ROW_Z   = 3'd2,
        REG_OFF_XY  = 3'd3,
        REG_OFF_Z   = 3'd4,
        REG_DIST    = 3'd5,
        REG_TARGET  = 3'd6,
        REG_CULL    = 3'd7
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CAMZ,
        ST_CAMX,
        ST_CAMY,
        ST_PROJX,
        ST_DIVX,
        ST_PROJY,
        ST_DIVY,
        ST_WIND0,
        ST_WIND1,
        ST_WIND2,
        ST_EMIT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic       load_in;
        logic [1:0] cam_row;     // 0 x, 1 y, 2 z
        logic       cam_go;
        logic       proj_y;      // 0 x, 1 y
        logic       proj_load;
        logic       div_step;
        logic       proj_done;
        logic       hold_slot;   // write held vertex
        logic       hold_idx;
        logic       wind_mul;
        logic [1:0] emit_sel;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic near_drop;
        logic div_done;
        logic clockwise;
    } dp_stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction
endpackage
`default_nettype wire

// ----- hdl/tvpc_datapath.sv -----
`default_nettype none
module tvpc_datapath
    import tvpc_pkg::*;
#(
    parameter int NearClip = 6554
) (
    input  wire logic         aclk,
    input  wire dp_cmd_t      cmd,
    output dp_stat_t          stat,
    input  wire logic [47:0]  row_x,
    input  wire logic [47:0]  row_y,
    input  wire logic [47:0]  row_z,
    input  wire logic [63:0]  off_xy,
    input  wire logic [31:0]  off_z,
    input  wire logic [31:0]  scr_dist,
    input  wire logic [63:0]  target,
    input  wire logic [191:0] in_data,
    output logic [160:0]      out_data
);
    logic signed [31:0] mx_reg, my_reg, mz_reg;
    logic [95:0]        pass_reg;
    logic signed [31:0] cx_reg, cy_reg, cz_reg;
    logic signed [31:0] sx_reg, sy_reg;
    logic [63:0]        hpos_reg [2];
    logic [95:0]        hpass_reg [2];
    logic signed [67:0] pa_reg, pb_reg;
    logic [63:0]        num_reg;
    logic [31:0]        den_reg;
    logic [31:0]        rem_reg;
    logic [63:0]        quo_reg;
    logic [6:0]         cnt_reg;
    logic               neg_reg;
    logic [160:0]       out_reg;

    // one row of the camera transform: three 16x32 products and a sum
    logic [47:0]        row_sel;
    logic signed [31:0] off_sel;
    logic signed [49:0] dot;
    logic signed [37:0] sh;
    logic signed [31:0] cam;
    always_comb begin
        case (cmd.cam_row)
            2'd0:    begin row_sel = row_x; off_sel = off_xy[31:0]; end
            2'd1:    begin row_sel = row_y; off_sel = off_xy[63:32]; end
            default: begin row_sel = row_z; off_sel = off_z; end
        endcase
        dot = 50'(signed'(row_sel[15:0]) * mx_reg) + 50'(signed'(row_sel[31:16]) * my_reg)
            + 50'(signed'(row_sel[47:32]) * mz_reg);
        sh  = 38'(dot >>> CoefFrac);
        cam = sat32(66'(sh) + 66'(off_sel));
    end

    logic signed [31:0] csel;
    logic [31:0]        cmag;
    logic [32:0]        trial;
    always_comb begin
        csel  = cmd.proj_y ? cy_reg : cx_reg;
        cmag  = csel[31] ? 32'(-csel) : csel;
        trial = {rem_reg, num_reg[63]} - {1'b0, den_reg};
    end

    // projection result with clamp, sign and offset
    logic [32:0]        qclamp;
    logic signed [31:0] toff;
    logic signed [31:0] pres;
    always_comb begin
        qclamp = (quo_reg > 64'h1_0000_0000) ? 33'h1_0000_0000 : quo_reg[32:0];
        toff   = cmd.proj_y ? target[63:32] : target[31:0];
        pres   = neg_reg ? sat32(66'(toff) - 66'(qclamp))
                         : sat32(66'(toff) + 66'(qclamp));
    end

    // winding differences
    logic signed [32:0] dx21, dy01, dy21, dx01;
    logic signed [67:0] wd;
    always_comb begin
        dx21 = 33'(sx_reg) - 33'(signed'(hpos_reg[1][31:0]));
        dy01 = 33'(signed'(hpos_reg[0][63:32])) - 33'(signed'(hpos_reg[1][63:32]));
        dy21 = 33'(sy_reg) - 33'(signed'(hpos_reg[1][63:32]));
        dx01 = 33'(signed'(hpos_reg[0][31:0])) - 33'(signed'(hpos_reg[1][31:0]));
        wd   = pa_reg - pb_reg;
    end

    always_comb begin
        stat.near_drop = (cz_reg > -32'sd1 * 32'(NearClip));
        stat.div_done  = (cnt_reg == 7'd0);
        stat.clockwise = !wd[67] && (wd != 68'sd0);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            mx_reg   <= in_data[31:0];
            my_reg   <= in_data[63:32];
            mz_reg   <= in_data[95:64];
            pass_reg <= in_data[191:96];
        end
        if (cmd.cam_go) begin
            case (cmd.cam_row)
                2'd0:    cx_reg <= cam;
                2'd1:    cy_reg <= cam;
                default: cz_reg <= cam;
            endcase
        end
        if (cmd.proj_load) begin
            num_reg <= 64'(cmag) * 64'(scr_dist);
            den_reg <= 32'(-cz_reg);
            rem_reg <= '0;
            quo_reg <= '0;
            cnt_reg <= 7'd64;
            neg_reg <= csel[31] ^ cmd.proj_y;
        end else if (cmd.div_step) begin
            num_reg <= {num_reg[62:0], 1'b0};
            cnt_reg <= cnt_reg - 7'd1;
            if (!trial[32]) begin
                rem_reg <= trial[31:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[30:0], num_reg[63]};
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
        if (cmd.proj_done) begin
            if (cmd.proj_y) sy_reg <= pres;
            else            sx_reg <= pres;
        end
        if (cmd.hold_slot) begin
            hpos_reg[cmd.hold_idx]  <= {sy_reg, sx_reg};
            hpass_reg[cmd.hold_idx] <= pass_reg;
        end
        if (cmd.wind_mul) begin
            pa_reg <= 68'(dx21 * dy01);
            pb_reg <= 68'(dy21 * dx01);
        end
        if (cmd.out_load) begin
            case (cmd.emit_sel)
                2'd0:    out_reg <= {1'b0, hpass_reg[0], hpos_reg[0]};
                2'd1:    out_reg <= {1'b0, hpass_reg[1], hpos_reg[1]};
                default: out_reg <= {1'b1, pass_reg, sy_reg, sx_reg};
            endcase
        end
    end

    assign out_data = out_reg;
endmodule
`default_nettype wire

// ----- hdl/tvpc_control.sv -----
`default_nettype none
module tvpc_control
    import tvpc_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_fire,
    input  wire logic  in_first,
    output logic       in_ready,
    output logic       out_valid,
    input  wire logic  out_ready,
    input  wire logic  cull_en,
    input  wire dp_stat_t stat,
    output dp_cmd_t    cmd
);
    state_t     state_reg, state_next;
    logic [1:0] slot_reg, slot_next;
    logic       drop_reg, drop_next;
    logic [1:0] emit_reg, emit_next;
    logic       ov_reg, ov_next;
    logic [1:0] s;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            slot_reg  <= 2'd0;
            drop_reg  <= 1'b0;
            emit_reg  <= 2'd0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            drop_reg  <= drop_next;
            emit_reg  <= emit_next;
            ov_reg    <= ov_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        slot_next  = slot_reg;
        drop_next  = drop_reg;
        emit_next  = emit_reg;
        ov_next    = ov_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        s = (in_first || slot_reg == 2'd3) ? 2'd0 : slot_reg;
        cmd.proj_y   = (state_reg == ST_PROJY) || (state_reg == ST_DIVY);
        cmd.emit_sel = emit_reg;
        if (ov_reg && out_ready) ov_next = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_fire) begin
                    slot_next = (s == 2'd2) ? 2'd0 : s + 2'd1;
                    if (s == 2'd0) drop_next = 1'b0;
                    if (!(s != 2'd0 && drop_reg && !in_first)) begin
                        cmd.load_in = 1'b1;
                        emit_next   = s;
                        state_next  = ST_CAMZ;
                    end
                end
            end
            ST_CAMZ: begin
                cmd.cam_row = 2'd2;
                cmd.cam_go  = 1'b1;
                state_next  = ST_CAMX;
            end
            ST_CAMX: begin
                if (stat.near_drop) begin
                    drop_next  = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    cmd.cam_row = 2'd0;
                    cmd.cam_go  = 1'b1;
                    state_next  = ST_CAMY;
                end
            end
            ST_CAMY: begin
                cmd.cam_row = 2'd1;
                cmd.cam_go  = 1'b1;
                state_next  = ST_PROJX;
            end
            ST_PROJX, ST_PROJY: begin
                cmd.proj_load = 1'b1;
                state_next = (state_reg == ST_PROJX) ? ST_DIVX : ST_DIVY;
            end
            ST_DIVX, ST_DIVY: begin
                if (stat.div_done) begin
                    cmd.proj_done = 1'b1;
                    if (state_reg == ST_DIVX) state_next = ST_PROJY;
                    else if (emit_reg != 2'd2) state_next = ST_WIND0;
                    else state_next = ST_WIND1;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_WIND0: begin
                // first or second vertex is held
                cmd.hold_slot = 1'b1;
                cmd.hold_idx  = emit_reg[0];
                state_next    = ST_IDLE;
            end
            ST_WIND1: begin
                cmd.wind_mul = 1'b1;
                state_next   = ST_WIND2;
            end
            ST_WIND2: begin
                if (cull_en && !stat.clockwise) state_next = ST_IDLE;
                else begin
                    emit_next  = 2'd0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!ov_reg || out_ready) begin
                    cmd.out_load = 1'b1;
                    ov_next      = 1'b1;
                    emit_next    = emit_reg + 2'd1;
                    if (emit_reg == 2'd2) state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_valid = ov_reg;
endmodule
`default_nettype wire

// ----- hdl/triangle_vertex_project_cull.sv -----
`default_nettype none
// Perspective vertex transform with near-plane and back-face culling. One
// vertex is taken per s_ transfer, a new one only once the last is through:
// a held vertex passes the accepting state, three transform states, and for
// x and y a load state and 64 restoring divider steps of one bit plus a
// finishing step, then a hold state, so the shared divider sets the rate.
// The third vertex does the winding multiply and compare in place of the hold,
// then loads its three results. A vertex that hits the near plane is dropped
// after its z transform; the rest of its triangle is discarded on acceptance.
// The three results of a kept triangle leave through an output register; the
// next vertex may be taken while the last result still waits there. Config
// writes only while idle: the user is bound, the block does not enforce it.
module triangle_vertex_project_cull
    import tvpc_pkg::*;
#(
    parameter int NearClip = 6554
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // model_x, model_y, model_z, vertex_color, tex_u, tex_v
    input  wire logic [191:0] s_tdata,
    // first_of_mesh
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // screen_x, screen_y, out_color, out_u, out_v
    output logic [159:0]      m_tdata,
    output logic              m_tlast,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [63:0]  cfg_data
);
    logic [47:0] row_x_reg, row_y_reg, row_z_reg;
    logic [63:0] off_xy_reg, target_reg;
    logic [31:0] off_z_reg, dist_reg;
    logic        cull_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_x_reg  <= '0;
            row_y_reg  <= '0;
            row_z_reg  <= '0;
            off_xy_reg <= '0;
            off_z_reg  <= '0;
            dist_reg   <= 32'h0001_0000;
            target_reg <= '0;
            cull_reg   <= 1'b1;
        end else if (cfg_valid) begin
            case (reg_idx_t'(cfg_index))
                REG_ROW_X:  row_x_reg  <= cfg_data[47:0];
                REG_ROW_Y:  row_y_reg  <= cfg_data[47:0];
                REG_ROW_Z:  row_z_reg  <= cfg_data[47:0];
                REG_OFF_XY: off_xy_reg <= cfg_data;
                REG_OFF_Z:  off_z_reg  <= cfg_data[31:0];
                REG_DIST:   dist_reg   <= cfg_data[31:0];
                REG_TARGET: target_reg <= cfg_data;
                REG_CULL:   cull_reg   <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    dp_cmd_t      cmd;
    dp_stat_t     stat;
    logic [160:0] out_data;
    logic         in_fire;

    assign in_fire = s_tvalid && s_tready;

    tvpc_control u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_first  (s_tuser),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cull_en   (cull_reg),
        .stat      (stat),
        .cmd       (cmd)
    );

    tvpc_datapath #(.NearClip(NearClip)) u_dp (
        .aclk     (aclk),
        .cmd      (cmd),
        .stat     (stat),
        .row_x    (row_x_reg),
        .row_y    (row_y_reg),
        .row_z    (row_z_reg),
        .off_xy   (off_xy_reg),
        .off_z    (off_z_reg),
        .scr_dist (dist_reg),
        .target   (target_reg),
        .in_data  (s_tdata),
        .out_data (out_data)
    );

    assign m_tdata = out_data[159:0];
    assign m_tlast = out_data[160];

`ifndef ASSERT_OFF
    // payload of a waiting result may not change
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");
    // no new vertex is taken while the first two results of a triangle are pending
    a_no_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("vertex accepted during emission");
`endif
endmodule
`default_nettype wire
